FILE: src/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef logic [4:0][31:0] chain_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] ROUND_PHASE1 = 7'd20;
  localparam logic [6:0] ROUND_PHASE2 = 7'd40;
  localparam logic [6:0] ROUND_PHASE3 = 7'd60;
  localparam logic [6:0] ROUND_LAST   = 7'd79;

  localparam logic [2:0] MAX_BYTES  = 3'd4;
  localparam logic [2:0] LAST_INDEX = 3'd4;
  localparam logic [5:0] LEN_POS    = 6'd56;

  typedef struct packed {
    logic        push;
    logic        step;
    logic [31:0] word;
  } sched_ctrl_t;

  typedef struct packed {
    logic       step;
    logic       fold;
    logic       restart;
    logic [6:0] round;
  } core_ctrl_t;

endpackage

`default_nettype wire

FILE: src/sha1_sched.sv
// ----------------------------------------------------------------------------
// sha1_sched
// Sixteen-word shift line: gathers the block words, then expands the
// message schedule one word per round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_sched
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire sched_ctrl_t ctrl,
  output logic [31:0]      w_cur
);

  logic [15:0][31:0] w;
  logic [31:0]       mix;
  logic [31:0]       expand;

  assign mix    = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign expand = {mix[30:0], mix[31]};
  assign w_cur  = w[0];

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int k = 0; k < 15; k++) begin
        w[k] <= w[k + 1];
      end
      w[15] <= ctrl.push ? ctrl.word : expand;
    end
  end

endmodule

`default_nettype wire

FILE: src/sha1_core.sv
// ----------------------------------------------------------------------------
// sha1_core
// Working variables, chaining words and the single shared round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_core
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire core_ctrl_t  ctrl,
  input  wire logic [31:0] w_cur,
  output chain_t           chain
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t;
  chain_t      sum;

  always_comb begin
    if (ctrl.round < ROUND_PHASE1) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctrl.round < ROUND_PHASE2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctrl.round < ROUND_PHASE3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_cur;
  end

  assign sum[0] = chain[0] + a;
  assign sum[1] = chain[1] + b;
  assign sum[2] = chain[2] + c;
  assign sum[3] = chain[3] + d;
  assign sum[4] = chain[4] + e;

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      chain <= {IV4, IV3, IV2, IV1, IV0};
      a <= IV0;
      b <= IV1;
      c <= IV2;
      d <= IV3;
      e <= IV4;
    end else if (ctrl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end else if (ctrl.fold) begin
      chain <= sum;
      a <= sum[0];
      b <= sum[1];
      c <= sum[2];
      d <= sum[3];
      e <= sum[4];
    end
  end

endmodule

`default_nettype wire

FILE: src/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 hash engine with byte packing, padding and digest output.
// ----------------------------------------------------------------------------
// One item at a time; the input stalls until the engine is idle again. An
// aligned four-byte word is packed as a whole word; an unaligned or short
// word is packed byte by byte instead. Every filled 64-byte block is then
// compressed in 80 rounds through the single round unit, followed by a
// fold into the chaining words. On a last word the pad byte and the zero
// fill follow (the fill per byte until aligned, then per word), then the
// 64-bit length as two words, then one or two blocks are compressed and
// the five digest words leave as five output transfers, after which the
// engine is back at its initial values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_engine_unit
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  state_t      state, state_next;
  state_t      ret, ret_next;
  state_t      after;
  logic [5:0]  pos;
  logic [2:0]  n;
  logic [31:0] data;
  logic        last_r;
  logic [31:0] acc;
  logic [63:0] bit_total;
  logic [6:0]  round;
  logic [2:0]  idx;

  logic        byte_put, word_put, put;
  logic [7:0]  byte_val;
  logic [31:0] word_val;
  logic [31:0] merged;
  logic [6:0]  pos_sum;
  logic        block_full;
  logic [2:0]  clamp;

  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;
  logic [31:0] w_cur;
  chain_t      chain;

  sha1_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w_cur(w_cur)
  );

  sha1_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (core_ctrl),
    .w_cur(w_cur),
    .chain(chain)
  );

  assign clamp = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;

  // Datapath control
  always_comb begin
    byte_put          = 1'b0;
    word_put          = 1'b0;
    byte_val          = 8'h00;
    word_val          = 32'h0;
    core_ctrl.step    = 1'b0;
    core_ctrl.fold    = 1'b0;
    core_ctrl.restart = 1'b0;
    core_ctrl.round   = round;
    sched_ctrl.step   = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_DATA: begin
        if (n != 3'd0) begin
          if (pos[1:0] == 2'd0 && n == MAX_BYTES) begin
            word_put = 1'b1;
            word_val = data;
          end else begin
            byte_put = 1'b1;
            byte_val = data[31:24];
          end
        end
      end
      ST_PAD: begin
        byte_put = 1'b1;
        byte_val = PAD_BYTE;
      end
      ST_ZERO: begin
        if (pos != LEN_POS) begin
          if (pos[1:0] == 2'd0) begin
            word_put = 1'b1;
          end else begin
            byte_put = 1'b1;
          end
        end
      end
      ST_LEN: begin
        word_put = 1'b1;
        word_val = pos[2] ? bit_total[31:0] : bit_total[63:32];
      end
      ST_COMP: begin
        core_ctrl.step  = 1'b1;
        sched_ctrl.step = 1'b1;
      end
      ST_FOLD: begin
        core_ctrl.fold = 1'b1;
      end
      ST_OUT: begin
        core_ctrl.restart = !out_stall && idx == LAST_INDEX;
      end
      default: ;
    endcase

    merged = acc;
    case (pos[1:0])
      2'd0: merged[31:24] = byte_val;
      2'd1: merged[23:16] = byte_val;
      2'd2: merged[15:8]  = byte_val;
      default: merged[7:0] = byte_val;
    endcase

    put             = byte_put | word_put;
    sched_ctrl.push = word_put | (byte_put && pos[1:0] == 2'd3);
    sched_ctrl.word = word_put ? word_val : merged;
    pos_sum         = {1'b0, pos} + (word_put ? 7'd4 : (byte_put ? 7'd1 : 7'd0));
    block_full      = pos_sum[6];
  end

  // Next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    after      = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (n == 3'd0) begin
          state_next = last_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: after = ST_ZERO;
      ST_ZERO: begin
        if (pos == LEN_POS) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: after = pos[2] ? ST_OUT : ST_LEN;
      ST_COMP: begin
        if (round == ROUND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: state_next = ret;
      ST_OUT: begin
        if (!out_stall && idx == LAST_INDEX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (put) begin
      if (block_full) begin
        state_next = ST_COMP;
        ret_next   = after;
      end else begin
        state_next = after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      pos       <= 6'd0;
      bit_total <= 64'd0;
      round     <= 7'd0;
      idx       <= 3'd0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (put) begin
        pos <= pos_sum[5:0];
      end
      if (byte_put) begin
        acc <= merged;
      end
      if (state == ST_IDLE && in_valid) begin
        data      <= data_word;
        n         <= clamp;
        last_r    <= last;
        bit_total <= bit_total + {58'd0, clamp, 3'd0};
      end
      if (state == ST_DATA) begin
        if (word_put) begin
          n <= 3'd0;
        end else if (byte_put) begin
          n    <= n - 3'd1;
          data <= {data[23:0], 8'h00};
        end
      end
      if (state == ST_COMP) begin
        round <= (round == ROUND_LAST) ? 7'd0 : round + 7'd1;
      end
      if (state == ST_OUT && !out_stall) begin
        idx <= (idx == LAST_INDEX) ? 3'd0 : idx + 3'd1;
      end
      if (core_ctrl.restart) begin
        pos       <= 6'd0;
        bit_total <= 64'd0;
      end
    end
  end

  assign in_stall    = state != ST_IDLE;
  assign out_valid   = state == ST_OUT;
  assign digest_word = chain[idx];
  assign word_index  = idx;
  assign last_word   = idx == LAST_INDEX;

endmodule

`default_nettype wire
